### hw/rtl/bq_pkg.sv
// ----------------------------------------------------------------------------
// bq_pkg
// Shared types, constants and microcode for the biquad DF2T section.
// ----------------------------------------------------------------------------
package bq_pkg;

    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_COEF_WIDTH     = 24;
    localparam int DEF_COEF_FRAC_BITS = 20;

    localparam int DLY_W   = 40;
    localparam int ACC_W   = DLY_W + 2;
    localparam int STEP_W  = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DLY_W-1:0] DLY_MAX = {1'b0, {(DLY_W-1){1'b1}}};
    localparam logic signed [DLY_W-1:0] DLY_MIN = {1'b1, {(DLY_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0 = 3'd0,
        CFG_B1 = 3'd1,
        CFG_B2 = 3'd2,
        CFG_A1 = 3'd3,
        CFG_A2 = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        COND_NONE = 2'd0,
        COND_IN   = 2'd1,
        COND_OUT  = 2'd2
    } t_cond;

    typedef enum logic [2:0] {
        SEL_B0 = 3'd0,
        SEL_B1 = 3'd1,
        SEL_B2 = 3'd2,
        SEL_A1 = 3'd3,
        SEL_A2 = 3'd4
    } t_coef_sel;

    typedef enum logic {
        SRC_X = 1'b0,
        SRC_Y = 1'b1
    } t_src;

    typedef enum logic [2:0] {
        ACC_HOLD      = 3'd0,
        ACC_PROD_D1   = 3'd1,
        ACC_PROD_D2   = 3'd2,
        ACC_ADD_PROD  = 3'd3,
        ACC_LOAD_PROD = 3'd4
    } t_acc_op;

    typedef struct packed {
        t_cond              cond;
        logic               x_ld;
        logic               mul_en;
        t_coef_sel          coef_sel;
        t_src               mul_src;
        t_acc_op            acc_op;
        logic               y_ld;
        logic               out_ld;
        logic               d1_ld;
        logic               d2_ld;
        logic               jmp;
        logic [STEP_W-1:0]  jmp_addr;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_stat;

    localparam t_ctrl CTRL_NOP = '{
        cond:     COND_NONE,
        x_ld:     1'b0,
        mul_en:   1'b0,
        coef_sel: SEL_B0,
        mul_src:  SRC_X,
        acc_op:   ACC_HOLD,
        y_ld:     1'b0,
        out_ld:   1'b0,
        d1_ld:    1'b0,
        d2_ld:    1'b0,
        jmp:      1'b0,
        jmp_addr: '0
    };

    // microcode: one control word per step
    function automatic t_ctrl rom_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = CTRL_NOP;
        case (step)
            3'd0: begin
                w.cond = COND_IN;
                w.x_ld = 1'b1;
            end
            3'd1: begin
                w.mul_en   = 1'b1;
                w.coef_sel = SEL_B0;
                w.mul_src  = SRC_X;
            end
            3'd2: begin
                w.acc_op   = ACC_PROD_D1;
                w.mul_en   = 1'b1;
                w.coef_sel = SEL_B1;
                w.mul_src  = SRC_X;
            end
            3'd3: begin
                w.y_ld   = 1'b1;
                w.acc_op = ACC_PROD_D2;
            end
            3'd4: begin
                w.cond     = COND_OUT;
                w.out_ld   = 1'b1;
                w.mul_en   = 1'b1;
                w.coef_sel = SEL_A1;
                w.mul_src  = SRC_Y;
            end
            3'd5: begin
                w.acc_op   = ACC_ADD_PROD;
                w.mul_en   = 1'b1;
                w.coef_sel = SEL_B2;
                w.mul_src  = SRC_X;
            end
            3'd6: begin
                w.d1_ld    = 1'b1;
                w.acc_op   = ACC_LOAD_PROD;
                w.mul_en   = 1'b1;
                w.coef_sel = SEL_A2;
                w.mul_src  = SRC_Y;
            end
            3'd7: begin
                w.d2_ld    = 1'b1;
                w.jmp      = 1'b1;
                w.jmp_addr = '0;
            end
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

    // saturate an accumulator value to the delay range
    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
        logic hi_same;
        hi_same = (&v[ACC_W-1:DLY_W-1]) | (~|v[ACC_W-1:DLY_W-1]);
        if (hi_same) begin
            return v[DLY_W-1:0];
        end else if (v[ACC_W-1]) begin
            return DLY_MIN;
        end else begin
            return DLY_MAX;
        end
    endfunction

endpackage

### hw/rtl/bq_seq.sv
// ----------------------------------------------------------------------------
// bq_seq
// Step counter and microcode ROM; one control word per cycle, NOP while held.
// ----------------------------------------------------------------------------
module bq_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bq_pkg::t_stat  i_stat,
    output bq_pkg::t_ctrl  o_ctrl,
    output logic           o_in_ready
);
    import bq_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             rom;
    logic              go;

    assign rom = rom_word(r_step);

    always_comb begin
        case (rom.cond)
            COND_NONE: go = 1'b1;
            COND_IN:   go = i_stat.in_valid;
            COND_OUT:  go = i_stat.out_free;
            default:   go = 1'b0;
        endcase
    end

    always_comb begin
        if (!go) begin
            n_step = r_step;
        end else if (rom.jmp) begin
            n_step = rom.jmp_addr;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    assign o_ctrl     = go ? rom : CTRL_NOP;
    assign o_in_ready = (rom.cond == COND_IN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### hw/rtl/bq_dp.sv
// ----------------------------------------------------------------------------
// bq_dp
// Datapath: coefficient registers, shared multiplier, accumulator, delays,
// rounding/saturation and output register.
// ----------------------------------------------------------------------------
module bq_dp #(
    parameter int SAMPLE_WIDTH   = bq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH     = bq_pkg::DEF_COEF_WIDTH,
    parameter int COEF_FRAC_BITS = bq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bq_pkg::t_ctrl                 i_ctrl,
    input  logic                          i_cfg_we,
    input  logic [bq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COEF_WIDTH-1:0]         i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                          i_out_stall,
    output logic                          o_out_free,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);
    import bq_pkg::*;

    localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int RW = ACC_W + 1;
    localparam logic signed [RW-1:0] HALF  = RW'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [RW-1:0] Y_MAX = RW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [RW-1:0] Y_MIN = RW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
    localparam logic [COEF_WIDTH-1:0] B0_RST = COEF_WIDTH'(64'd1 << COEF_FRAC_BITS);

    logic signed [COEF_WIDTH-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y, n_y;
    logic signed [DLY_W-1:0]        r_prod, n_prod;
    logic signed [ACC_W-1:0]        r_acc, n_acc;
    logic signed [DLY_W-1:0]        r_d1, r_d2;
    logic signed [SAMPLE_WIDTH-1:0] r_sample_out;
    logic                           r_out_valid;

    logic signed [COEF_WIDTH-1:0]   mul_c;
    logic signed [SAMPLE_WIDTH-1:0] mul_s;
    logic signed [PW-1:0]           prod_full;
    logic signed [RW-1:0]           rnd_sum, rnd_shr;
    logic signed [ACC_W-1:0]        d2_sum;

    always_comb begin
        case (i_ctrl.coef_sel)
            SEL_B0:  mul_c = r_b0;
            SEL_B1:  mul_c = r_b1;
            SEL_B2:  mul_c = r_b2;
            SEL_A1:  mul_c = r_a1;
            SEL_A2:  mul_c = r_a2;
            default: mul_c = r_b0;
        endcase
    end

    assign mul_s     = (i_ctrl.mul_src == SRC_Y) ? r_y : r_x;
    assign prod_full = PW'(mul_c) * PW'(mul_s);

    generate
        if (PW > DLY_W) begin : g_clamp
            logic hi_same;
            assign hi_same = (&prod_full[PW-1:DLY_W-1]) | (~|prod_full[PW-1:DLY_W-1]);
            assign n_prod  = hi_same ? prod_full[DLY_W-1:0]
                           : (prod_full[PW-1] ? DLY_MIN : DLY_MAX);
        end else begin : g_ext
            assign n_prod = DLY_W'(prod_full);
        end
    endgenerate

    always_comb begin
        case (i_ctrl.acc_op)
            ACC_HOLD:      n_acc = r_acc;
            ACC_PROD_D1:   n_acc = ACC_W'(r_prod) + ACC_W'(r_d1);
            ACC_PROD_D2:   n_acc = ACC_W'(r_prod) + ACC_W'(r_d2);
            ACC_ADD_PROD:  n_acc = r_acc + ACC_W'(r_prod);
            ACC_LOAD_PROD: n_acc = ACC_W'(r_prod);
            default:       n_acc = r_acc;
        endcase
    end

    // round half up, then saturate to the sample range
    assign rnd_sum = RW'(r_acc) + HALF;
    assign rnd_shr = rnd_sum >>> COEF_FRAC_BITS;

    always_comb begin
        if (rnd_shr > Y_MAX) begin
            n_y = Y_MAX[SAMPLE_WIDTH-1:0];
        end else if (rnd_shr < Y_MIN) begin
            n_y = Y_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            n_y = rnd_shr[SAMPLE_WIDTH-1:0];
        end
    end

    assign d2_sum     = r_acc + ACC_W'(r_prod);
    assign o_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= B0_RST;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_B0:  r_b0 <= i_cfg_data;
                CFG_B1:  r_b1 <= i_cfg_data;
                CFG_B2:  r_b2 <= i_cfg_data;
                CFG_A1:  r_a1 <= i_cfg_data;
                CFG_A2:  r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1        <= '0;
            r_d2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.d1_ld) begin
                r_d1 <= sat_dly(r_acc);
            end
            if (i_ctrl.d2_ld) begin
                r_d2 <= sat_dly(d2_sum);
            end
            if (i_ctrl.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.x_ld) begin
            r_x <= i_sample_in;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= n_prod;
        end
        r_acc <= n_acc;
        if (i_ctrl.y_ld) begin
            r_y <= n_y;
        end
        if (i_ctrl.out_ld) begin
            r_sample_out <= r_y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

### hw/rtl/biquad_df2t_section_unit.sv
// ----------------------------------------------------------------------------
// biquad_df2t_section_unit
// Second-order IIR section, transposed direct form II, fixed point.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | i_in_valid, o_in_stall, i_sample_in  | in
//   output  | o_out_valid, i_out_stall, o_sample_out| out
//   config  | i_cfg_we, i_cfg_idx, i_cfg_data      | in
//
// Each item passes through a fixed 8-step microcode loop that runs five
// products through one shared multiplier.
// The result is registered; the next sample is taken while it waits.
// A stalled output holds the loop at the output step only.
// Synchronous active-low reset clears delays and control and loads unity
// pass-through coefficients (b0 = 1.0, all others zero).
// ----------------------------------------------------------------------------
module biquad_df2t_section_unit #(
    parameter int SAMPLE_WIDTH   = bq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH     = bq_pkg::DEF_COEF_WIDTH,
    parameter int COEF_FRAC_BITS = bq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COEF_WIDTH-1:0]          i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);
    import bq_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  in_ready;
    logic  out_free;

    assign stat.in_valid = i_in_valid;
    assign stat.out_free = out_free;
    assign o_in_stall    = !in_ready;

    bq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_ready (in_ready)
    );

    bq_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_WIDTH     (COEF_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_out_stall  (i_out_stall),
        .o_out_free   (out_free),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the transposed direct form II biquad section.
// A short directed table covers identity after reset, coefficient and sample
// extremes, round-half-up, writes to unused register indexes and delay
// saturation. Random coefficient sets (full range, extremes, near-stable)
// with random samples follow, under random input gaps and output stalls.
// Every output transfer is checked against an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module testbench;
    import bq_pkg::*;

    localparam int SW            = DEF_SAMPLE_WIDTH;
    localparam int CW            = DEF_COEF_WIDTH;
    localparam int FB            = DEF_COEF_FRAC_BITS;
    localparam int HALF_PERIOD   = 6;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 200;
    localparam int HOLD_SET      = 2;
    localparam int HOLD_BURST    = 40;
    localparam int NUM_SETS      = 16;
    localparam int ITEMS_PER_SET = 100;
    localparam int QUIET_SETS    = 2;
    localparam int MAX_REPORTS   = 40;
    localparam int B_TAME        = 1 << (FB - 1);
    localparam int A1_TAME       = 3 << (FB - 1);
    localparam int A2_TAME       = (9 << FB) / 10;
    localparam int SMALL_SPAN    = 256;

    localparam logic [CFG_IDX_W-1:0] FIRST_BAD_IDX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] LAST_BAD_IDX  = 3'd7;
    localparam logic [CW-1:0] COEF_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COEF_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] COEF_ONE  = CW'(1) << FB;
    localparam logic [CW-1:0] COEF_HALF = CW'(1) << (FB - 1);
    localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;
    typedef enum int {STYLE_FULL, STYLE_EDGE, STYLE_TAME} t_style;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CW-1:0]          data;
        logic signed [SW-1:0]   smp;
        logic                   has_exp;
        logic signed [SW-1:0]   exp_y;
    } t_row;

    localparam int PLAN_LEN = 33;

    t_row plan [PLAN_LEN] = '{
        '{ROW_SAMPLE, '0, '0, '0, 1'b1, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MAX, 1'b1, SMP_MAX},
        '{ROW_SAMPLE, '0, '0, SMP_MIN, 1'b1, SMP_MIN},
        '{ROW_SAMPLE, '0, '0, 16'sd1, 1'b1, 16'sd1},
        '{ROW_SAMPLE, '0, '0, -16'sd1, 1'b1, -16'sd1},
        '{ROW_WRITE, CFG_B0, COEF_MAX, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MAX, 1'b1, SMP_MAX},
        '{ROW_SAMPLE, '0, '0, SMP_MIN, 1'b1, SMP_MIN},
        '{ROW_WRITE, CFG_B0, COEF_MIN, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MIN, 1'b1, SMP_MAX},
        '{ROW_SAMPLE, '0, '0, SMP_MAX, 1'b1, SMP_MIN},
        '{ROW_WRITE, CFG_B0, COEF_HALF, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd1, 1'b1, 16'sd1},
        '{ROW_SAMPLE, '0, '0, -16'sd1, 1'b1, '0},
        '{ROW_WRITE, FIRST_BAD_IDX, {CW{1'b1}}, '0, 1'b0, '0},
        '{ROW_WRITE, LAST_BAD_IDX, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd3, 1'b1, 16'sd2},
        '{ROW_WRITE, CFG_B0, COEF_MAX, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_B1, COEF_MAX, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_B2, COEF_MAX, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_A1, COEF_MAX, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_A2, COEF_MAX, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MAX, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MAX, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MAX, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MAX, 1'b0, '0},
        '{ROW_WRITE, CFG_A1, COEF_MIN, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_A2, COEF_MIN, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MIN, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MIN, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MIN, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MAX, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, SMP_MAX, 1'b0, '0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CW-1:0]           i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [SW-1:0]    i_sample_in;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [SW-1:0]    o_sample_out;

    // section state as the bench sees it
    logic signed [CW-1:0]    k_b0 = COEF_ONE;
    logic signed [CW-1:0]    k_b1 = '0;
    logic signed [CW-1:0]    k_b2 = '0;
    logic signed [CW-1:0]    k_a1 = '0;
    logic signed [CW-1:0]    k_a2 = '0;
    logic signed [DLY_W-1:0] st_d1 = '0;
    logic signed [DLY_W-1:0] st_d2 = '0;

    logic signed [SW-1:0]    pending_y [$];

    int  n_cycles    = 0;
    int  n_samples   = 0;
    int  n_writes    = 0;
    int  n_results   = 0;
    int  n_errors    = 0;
    int  n_holds     = 0;
    int  rx_busy_pct = 0;
    bit  hold_request = 1'b0;

    biquad_df2t_section_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic longint clip_dly(input longint v);
        if (v > longint'(DLY_MAX)) begin
            return longint'(DLY_MAX);
        end
        if (v < longint'(DLY_MIN)) begin
            return longint'(DLY_MIN);
        end
        return v;
    endfunction

    // y = round(b0*x + d1), then d1/d2 update from x and the saturated y
    function automatic logic signed [SW-1:0] df2t_output(input logic signed [SW-1:0] x);
        longint xs;
        longint acc;
        longint yv;
        longint n1;
        longint n2;
        xs  = longint'(x);
        acc = clip_dly(longint'(k_b0) * xs) + longint'(st_d1);
        yv  = (acc + (longint'(1) <<< (FB - 1))) >>> FB;
        if (yv > longint'(SMP_MAX)) begin
            yv = longint'(SMP_MAX);
        end else if (yv < longint'(SMP_MIN)) begin
            yv = longint'(SMP_MIN);
        end
        n1 = clip_dly(longint'(k_b1) * xs) + clip_dly(longint'(k_a1) * yv) + longint'(st_d2);
        n2 = clip_dly(longint'(k_b2) * xs) + clip_dly(longint'(k_a2) * yv);
        st_d1 = DLY_W'(clip_dly(n1));
        st_d2 = DLY_W'(clip_dly(n2));
        return SW'(yv);
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return SW'(int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 20;
            default: return 50;
        endcase
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] smp, input logic has_exp,
                               input logic signed [SW-1:0] exp_y);
        logic signed [SW-1:0] y;
        i_in_valid  <= 1'b1;
        i_sample_in <= smp;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        y = df2t_output(smp);
        pending_y.push_back(has_exp ? exp_y : y);
        n_samples++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_B0: k_b0 = data;
            CFG_B1: k_b1 = data;
            CFG_B2: k_b2 = data;
            CFG_A1: k_a1 = data;
            CFG_A2: k_a2 = data;
            default: ;
        endcase
        n_writes++;
    endtask

    // the section keeps updating its delays after the output transfer
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_y.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_set(input t_style style);
        t_cfg_idx     r;
        logic [CW-1:0] v;
        r = r.first();
        for (int n = 0; n < r.num(); n++) begin
            case (style)
                STYLE_FULL: v = CW'($urandom);
                STYLE_EDGE: begin
                    case ($urandom_range(0, 3))
                        0: v = COEF_MAX;
                        1: v = COEF_MIN;
                        2: v = '0;
                        default: v = COEF_ONE;
                    endcase
                end
                default: begin
                    case (r)
                        CFG_A1: v = CW'(int'($urandom_range(0, 2 * A1_TAME)) - A1_TAME);
                        CFG_A2: v = CW'(-int'($urandom_range(0, A2_TAME)));
                        default: v = CW'(int'($urandom_range(0, 2 * B_TAME)) - B_TAME);
                    endcase
                end
            endcase
            write_reg(r, v);
            r = r.next();
        end
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(FIRST_BAD_IDX, LAST_BAD_IDX)), CW'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $time, n_cycles, pending_y.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin : rx_stall
        bit busy;
        int span;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                busy         = 1'b1;
                span         = LONG_HOLD;
                hold_request = 1'b0;
                n_holds++;
            end else begin
                busy = ($urandom_range(0, 99) < rx_busy_pct);
                span = $urandom_range(1, 11);
            end
            i_out_stall <= busy;
            repeat (span) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : out_check
        logic signed [SW-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_y.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("%0t: unexpected output transfer, expected none, actual %0d",
                             $time, o_sample_out);
                end
            end else begin
                want = pending_y.pop_front();
                if (o_sample_out !== want) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, want, o_sample_out);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_style style;
        int     gap_pct;
        bit     cfg_open;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        cfg_open    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].kind == ROW_WRITE) begin
                if (!cfg_open) begin
                    drain_and_settle();
                    cfg_open = 1'b1;
                end
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
                send_sample(plan[r].smp, plan[r].has_exp, plan[r].exp_y);
            end
        end

        for (int s = 0; s < NUM_SETS; s++) begin
            drain_and_settle();
            style = t_style'(s % 3);
            program_set(style);
            if (s >= NUM_SETS - QUIET_SETS) begin
                gap_pct     = 0;
                rx_busy_pct = 0;
            end else begin
                gap_pct     = pick_pct();
                rx_busy_pct = pick_pct();
            end
            // long output hold while samples keep coming back to back
            if (s == HOLD_SET) begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_SET; k++) begin
                if (gap_pct > 0 && !(s == HOLD_SET && k < HOLD_BURST) &&
                    $urandom_range(0, 99) < gap_pct) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge i_clk);
                end
                send_sample(pick_sample(), 1'b0, '0);
            end
        end

        drain_and_settle();
        $display("summary: %0d samples, %0d register writes, %0d output transfers checked",
                 n_samples, n_writes, n_results);
        $display("summary: directed table plus %0d random coefficient sets, %0d long output holds",
                 NUM_SETS, n_holds);
        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
